FILE: rtl/core/hrs_pkg.sv
// hrs_pkg: widths, command and status types, back state codes and the falloff table
// for the heightmap row shading unit; depends on nothing
package hrs_pkg;

    localparam int COL_W    = 10;
    localparam int SHADE_W  = 7;
    localparam int HEIGHT_W = 16;
    localparam int LEVEL_W  = 13;
    localparam int DIST_W   = 11;
    localparam int SHADOW_W = 14;
    localparam int LEN_W    = 6;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;

    localparam logic [DIST_W-1:0]         DIST_MAX     = 11'd2047;
    localparam logic [LEN_W-1:0]          RUN_MAX      = 6'd50;
    localparam logic signed [SHADE_W-1:0] SHADOW_SHADE = -7'sd50;

    typedef struct packed {
        logic [LEN_W-1:0]          run_len;
        logic [COL_W-1:0]          run_start;
        logic signed [SHADE_W-1:0] run_shade;
        logic                      tail;
        logic [COL_W-1:0]          tail_col;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_TAIL
    } back_state_t;

    function automatic logic signed [SHADE_W-1:0] falloff(input logic [LEN_W-1:0] idx);
        logic signed [SHADE_W-1:0] v;
        case (idx)
            6'd0:  v = 7'sd0;
            6'd1:  v = 7'sd45;
            6'd2:  v = 7'sd26;
            6'd3:  v = 7'sd18;
            6'd4:  v = 7'sd14;
            6'd5:  v = 7'sd11;
            6'd6:  v = 7'sd9;
            6'd7:  v = 7'sd8;
            6'd8:  v = 7'sd7;
            6'd9:  v = 7'sd6;
            6'd10, 6'd11: v = 7'sd5;
            6'd12, 6'd13, 6'd14: v = 7'sd4;
            6'd15, 6'd16, 6'd17, 6'd18, 6'd19: v = 7'sd3;
            6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28: v = 7'sd2;
            default: v = (idx <= RUN_MAX) ? 7'sd1 : 7'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/hrs_in_if.sv
// hrs_in_if: pixel channel, valid/ready with height and row start
// depends on hrs_pkg for field widths
interface hrs_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [hrs_pkg::HEIGHT_W-1:0]  height;
    logic                                 row_start;

    modport source (output valid, output height, output row_start, input ready);
    modport sink   (input valid, input height, input row_start, output ready);
endinterface

FILE: rtl/core/hrs_out_if.sv
// hrs_out_if: shade write channel, valid/ready with column, shade and last
// depends on hrs_pkg for field widths
interface hrs_out_if;
    logic                                valid;
    logic                                ready;
    logic [hrs_pkg::COL_W-1:0]           column;
    logic signed [hrs_pkg::SHADE_W-1:0]  shade;
    logic                                last;

    modport source (output valid, output column, output shade, output last, input ready);
    modport sink   (input valid, input column, input shade, input last, output ready);
endinterface

FILE: rtl/core/hrs_front.sv
// hrs_front: takes pixels, keeps the row state and turns each pixel that causes writes into a write command
// depends on hrs_pkg and hrs_in_if
module hrs_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    hrs_in_if.sink              in_ch,
    input  hrs_pkg::q_status_t  q_status,
    output logic                push,
    output hrs_pkg::cmd_t       cmd
);

    localparam int CNT_W = $clog2(MAX_WIDTH + 1);

    logic signed [hrs_pkg::LEVEL_W-1:0]  ref_height_reg, ref_height_next;
    logic [hrs_pkg::DIST_W-1:0]          run_distance_reg, run_distance_next;
    logic signed [hrs_pkg::SHADOW_W-1:0] shadow_count_reg, shadow_count_next;
    logic                                descent_mode_reg, descent_mode_next;
    logic                                seen_first_reg, seen_first_next;
    logic [CNT_W-1:0]                    column_count_reg, column_count_next;

    logic signed [hrs_pkg::LEVEL_W-1:0]  dy;
    logic signed [hrs_pkg::SHADOW_W-1:0] dy_w, ref_w, sc_dec;
    logic signed [hrs_pkg::LEVEL_W-1:0]  e_ref;
    logic [hrs_pkg::DIST_W-1:0]          e_rd, rd1, rd_m1;
    logic signed [hrs_pkg::SHADOW_W-1:0] e_sc;
    logic                                e_desc, e_seen;
    logic [CNT_W-1:0]                    e_cc;
    logic [hrs_pkg::LEN_W-1:0]           run_cnt;
    logic [hrs_pkg::COL_W-1:0]           x10, hl_start, dk_start;
    logic                                accept;

    assign accept      = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !q_status.full;

    assign dy     = in_ch.height[hrs_pkg::HEIGHT_W-1:3];
    assign e_ref  = in_ch.row_start ? '0 : ref_height_reg;
    assign e_rd   = in_ch.row_start ? '0 : run_distance_reg;
    assign e_sc   = in_ch.row_start ? '0 : shadow_count_reg;
    assign e_desc = in_ch.row_start ? 1'b0 : descent_mode_reg;
    assign e_seen = in_ch.row_start ? 1'b0 : seen_first_reg;
    assign e_cc   = in_ch.row_start ? '0 : column_count_reg;

    assign dy_w   = hrs_pkg::SHADOW_W'(dy);
    assign ref_w  = hrs_pkg::SHADOW_W'(e_ref);
    assign sc_dec = e_sc - 14'sd1;
    assign rd1    = (e_rd == hrs_pkg::DIST_MAX) ? e_rd : e_rd + 11'd1;
    assign rd_m1  = rd1 - 11'd1;
    assign run_cnt = (rd_m1 > 11'(hrs_pkg::RUN_MAX)) ? hrs_pkg::RUN_MAX
                                                     : hrs_pkg::LEN_W'(rd_m1);
    assign x10      = hrs_pkg::COL_W'(e_cc);
    assign hl_start = x10 - hrs_pkg::COL_W'(run_cnt);
    assign dk_start = x10 - hrs_pkg::COL_W'(rd1) + 10'd1;

    always_comb
    begin
        ref_height_next   = ref_height_reg;
        run_distance_next = run_distance_reg;
        shadow_count_next = shadow_count_reg;
        descent_mode_next = descent_mode_reg;
        seen_first_next   = seen_first_reg;
        column_count_next = column_count_reg;
        cmd.run_len       = '0;
        cmd.run_start     = dk_start;
        cmd.run_shade     = -hrs_pkg::falloff(run_cnt);
        cmd.tail          = 1'b0;
        cmd.tail_col      = x10;
        if (accept)
        begin
            ref_height_next   = e_ref;
            run_distance_next = e_rd;
            shadow_count_next = e_sc;
            descent_mode_next = e_desc;
            seen_first_next   = e_seen;
            column_count_next = e_cc;
            if (e_cc < CNT_W'(MAX_WIDTH))
            begin
                column_count_next = e_cc + 1'b1;
                run_distance_next = rd1;
                if (!e_seen)
                begin
                    ref_height_next = dy;
                    seen_first_next = 1'b1;
                end
                else if (e_sc != 14'sd0)
                begin
                    if (dy_w < sc_dec)
                    begin
                        shadow_count_next = sc_dec;
                        cmd.tail          = 1'b1;
                    end
                    else
                    begin
                        // shadow ends, level becomes the new reference
                        shadow_count_next = '0;
                        ref_height_next   = dy;
                        run_distance_next = 11'd1;
                    end
                end
                else if (dy > e_ref)
                begin
                    if (dy_w - ref_w != 14'sd1)
                    begin
                        if (e_desc)
                            cmd.run_len = run_cnt;
                    end
                    else if (!e_desc)
                    begin
                        cmd.run_len   = run_cnt;
                        cmd.run_start = hl_start;
                        cmd.run_shade = hrs_pkg::falloff(run_cnt);
                    end
                    descent_mode_next = 1'b0;
                    ref_height_next   = dy;
                    run_distance_next = 11'd1;
                end
                else if (dy < e_ref)
                begin
                    if (e_desc)
                        cmd.run_len = run_cnt;
                    if (ref_w - dy_w != 14'sd1)
                    begin
                        shadow_count_next = ref_w;
                        cmd.tail          = 1'b1;
                    end
                    else
                        descent_mode_next = 1'b1;
                    ref_height_next   = dy;
                    run_distance_next = 11'd1;
                end
            end
        end
    end

    assign push = accept && ((cmd.run_len != '0) || cmd.tail);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_height_reg   <= '0;
            run_distance_reg <= '0;
            shadow_count_reg <= '0;
            descent_mode_reg <= 1'b0;
            seen_first_reg   <= 1'b0;
            column_count_reg <= '0;
        end
        else
        begin
            ref_height_reg   <= ref_height_next;
            run_distance_reg <= run_distance_next;
            shadow_count_reg <= shadow_count_next;
            descent_mode_reg <= descent_mode_next;
            seen_first_reg   <= seen_first_next;
            column_count_reg <= column_count_next;
        end
    end

    a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cmd.run_len <= hrs_pkg::RUN_MAX))
        else $error("run command longer than the falloff table");

    a_cmd_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((cmd.run_len != '0) || cmd.tail))
        else $error("command with no writes queued");

    a_col_sat: assert property (@(posedge clk) disable iff (!rst_n)
        column_count_reg <= CNT_W'(MAX_WIDTH))
        else $error("column count past row width");

endmodule

FILE: rtl/core/hrs_cmd_fifo.sv
// hrs_cmd_fifo: short command queue between the front and the back
// depends on hrs_pkg
module hrs_cmd_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hrs_pkg::cmd_t       push_data,
    input  logic                pop,
    output hrs_pkg::cmd_t       pop_data,
    output hrs_pkg::q_status_t  status
);

    hrs_pkg::cmd_t                mem_reg [hrs_pkg::QDEPTH];
    logic [hrs_pkg::QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [hrs_pkg::QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [hrs_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign status.full  = (count_reg == hrs_pkg::QCNT_W'(hrs_pkg::QDEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("command queue underflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= hrs_pkg::QCNT_W'(hrs_pkg::QDEPTH))
        else $error("command queue count out of range");

endmodule

FILE: rtl/core/hrs_back.sv
// hrs_back: expands queued commands into single shade writes behind an output register
// depends on hrs_pkg and hrs_out_if
module hrs_back (
    input  logic                clk,
    input  logic                rst_n,
    input  hrs_pkg::cmd_t       cmd,
    input  hrs_pkg::q_status_t  q_status,
    output logic                pop,
    hrs_out_if.source           out_ch
);

    hrs_pkg::back_state_t             state_reg, state_next;
    logic [hrs_pkg::LEN_W-1:0]        cnt_reg;
    logic [hrs_pkg::COL_W-1:0]        col_reg;
    logic signed [hrs_pkg::SHADE_W-1:0] shade_reg;
    logic                             tail_reg;
    logic [hrs_pkg::COL_W-1:0]        tail_col_reg;

    logic                             out_valid_reg;
    logic [hrs_pkg::COL_W-1:0]        out_column_reg;
    logic signed [hrs_pkg::SHADE_W-1:0] out_shade_reg;
    logic                             out_last_reg;

    logic                             adv, emit, beat_last;
    logic [hrs_pkg::COL_W-1:0]        beat_col;
    logic signed [hrs_pkg::SHADE_W-1:0] beat_shade;

    assign adv = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hrs_pkg::BK_IDLE:
                if (!q_status.empty)
                    state_next = (cmd.run_len != '0) ? hrs_pkg::BK_RUN : hrs_pkg::BK_TAIL;
            hrs_pkg::BK_RUN:
                if (adv && (cnt_reg == 6'd1))
                    state_next = tail_reg ? hrs_pkg::BK_TAIL : hrs_pkg::BK_IDLE;
            hrs_pkg::BK_TAIL:
                if (adv)
                    state_next = hrs_pkg::BK_IDLE;
            default:
                state_next = hrs_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop        = 1'b0;
        emit       = 1'b0;
        beat_col   = col_reg;
        beat_shade = shade_reg;
        beat_last  = 1'b0;
        unique case (state_reg)
            hrs_pkg::BK_IDLE:
                pop = !q_status.empty;
            hrs_pkg::BK_RUN:
            begin
                emit      = adv;
                beat_last = (cnt_reg == 6'd1) && !tail_reg;
            end
            hrs_pkg::BK_TAIL:
            begin
                emit       = adv;
                beat_col   = tail_col_reg;
                beat_shade = hrs_pkg::SHADOW_SHADE;
                beat_last  = 1'b1;
            end
            default:
                pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hrs_pkg::BK_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
                cnt_reg <= cmd.run_len;
            else if (emit && (state_reg == hrs_pkg::BK_RUN))
                cnt_reg <= cnt_reg - 1'b1;
            if (adv)
                out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            col_reg      <= cmd.run_start;
            shade_reg    <= cmd.run_shade;
            tail_reg     <= cmd.tail;
            tail_col_reg <= cmd.tail_col;
        end
        else if (emit && (state_reg == hrs_pkg::BK_RUN))
            col_reg <= col_reg + 1'b1;
        if (emit)
        begin
            out_column_reg <= beat_col;
            out_shade_reg  <= beat_shade;
            out_last_reg   <= beat_last;
        end
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.column = out_column_reg;
    assign out_ch.shade  = out_shade_reg;
    assign out_ch.last   = out_last_reg;

    a_run_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hrs_pkg::BK_RUN) |-> (cnt_reg != '0))
        else $error("run state with no writes left");

    a_tail_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hrs_pkg::BK_TAIL) |-> tail_reg)
        else $error("shadow write without a queued shadow");

    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg != hrs_pkg::BK_IDLE))
        else $error("popped command not started");

endmodule

FILE: rtl/core/heightmap_row_shading_unit.sv
// heightmap_row_shading_unit: top level, front, command queue and back
// depends on hrs_pkg, hrs_in_if, hrs_out_if, hrs_front, hrs_cmd_fifo, hrs_back
//
// Takes one heightmap pixel per beat on in_ch, left to right along a row, with
// row_start on the first pixel of each row, and gives (column, shade) writes on
// out_ch, last marking the final write of a pixel. The front takes a pixel every
// cycle while the four-entry command queue has room, including pixels that write
// nothing. The back loads a command in its idle state and turns it into writes at
// one per cycle while out_ch is ready, through its output register; a pixel causes
// up to 51 writes, and the back takes no new command while writing one. This single
// write port sets the sustained rate; pixels past MAX_WIDTH in a row have no effect.
module heightmap_row_shading_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    hrs_in_if.sink     in_ch,
    hrs_out_if.source  out_ch
);

    hrs_pkg::cmd_t       push_cmd;
    hrs_pkg::cmd_t       pop_cmd;
    hrs_pkg::q_status_t  q_status;
    logic                push;
    logic                pop;

    hrs_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .q_status (q_status),
        .push     (push),
        .cmd      (push_cmd)
    );

    hrs_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .status    (q_status)
    );

    hrs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (pop_cmd),
        .q_status (q_status),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule

FILE: test/tb_top.sv
// tb_top: self-checking bench for heightmap_row_shading_unit, predicting shade writes per pixel
// depends on hrs_pkg, hrs_in_if, hrs_out_if and the unit's rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_MAX      = 1024;
    localparam int RUN_CAP      = 51;
    localparam int DIST_CAP     = 2047;
    localparam int SHADOW_LEVEL = -50;
    localparam int LEVEL_LO     = -4096;
    localparam int LEVEL_HI     = 4095;

    typedef struct packed {
        logic [hrs_pkg::COL_W-1:0]          column;
        logic signed [hrs_pkg::SHADE_W-1:0] shade;
        logic                               last;
    } shade_write_t;

    logic clk;
    logic rst_n;

    hrs_in_if  in_ch ();
    hrs_out_if out_ch ();

    heightmap_row_shading_unit #(.MAX_WIDTH(ROW_MAX)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    shade_write_t pending_shades[$];
    int           pixel_cols[$];
    int           pixel_shades[$];

    int ref_level;
    int run_len;
    int shadow_ctr;
    int next_col;
    bit descending;
    bit row_seen;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_len      = 0;
    int error_count   = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // sink side, with an occasional long hold-off
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    function automatic int falloff_weight(input int idx);
        case (idx)
            0: return 0;
            1: return 45;
            2: return 26;
            3: return 18;
            4: return 14;
            5: return 11;
            6: return 9;
            7: return 8;
            8: return 7;
            9: return 6;
            10, 11: return 5;
            12, 13, 14: return 4;
            default: return (idx < 20) ? 3 : (idx < 29) ? 2 : 1;
        endcase
    endfunction

    function automatic void clear_row_state();
        ref_level  = 0;
        run_len    = 0;
        shadow_ctr = 0;
        descending = 1'b0;
        row_seen   = 1'b0;
        next_col   = 0;
    endfunction

    function automatic void note_write(input int col, input int shade);
        if (pixel_cols.size() < RUN_CAP)
        begin
            pixel_cols.push_back(col);
            pixel_shades.push_back(shade);
        end
    endfunction

    function automatic void darken_run(input int x);
        int len;
        len = run_len - 1;
        if (len > RUN_CAP - 1)
            len = RUN_CAP - 1;
        for (int k = 1; k <= len; k++)
            note_write(x - run_len + k, -falloff_weight(len));
    endfunction

    function automatic void predict_shades(input logic signed [hrs_pkg::HEIGHT_W-1:0] h,
                                           input logic rs);
        int lvl;
        int x;
        int len;
        lvl = int'(h >>> 3);
        pixel_cols.delete();
        pixel_shades.delete();
        if (rs)
            clear_row_state();
        if (next_col >= ROW_MAX)
            return;
        x = next_col;
        next_col++;
        if (run_len < DIST_CAP)
            run_len++;
        if (!row_seen)
        begin
            ref_level = lvl;
            row_seen  = 1'b1;
            return;
        end
        if (shadow_ctr != 0)
        begin
            shadow_ctr--;
            if (lvl < shadow_ctr)
            begin
                note_write(x, SHADOW_LEVEL);
                return;
            end
            shadow_ctr = 0;
            ref_level  = lvl;
            run_len    = 1;
        end
        if (lvl > ref_level)
        begin
            if (lvl - ref_level != 1)
            begin
                if (descending)
                    darken_run(x);
            end
            else if (!descending)
            begin
                len = (run_len > RUN_CAP) ? RUN_CAP : run_len;
                for (int k = len - 1; k >= 1; k--)
                    note_write(x - k, falloff_weight(len - 1));
            end
            descending = 1'b0;
            ref_level  = lvl;
            run_len    = 1;
        end
        else if (lvl < ref_level)
        begin
            if (descending)
                darken_run(x);
            if (ref_level - lvl != 1)
            begin
                shadow_ctr = ref_level;
                note_write(x, SHADOW_LEVEL);
            end
            else
            begin
                descending = 1'b1;
            end
            ref_level = lvl;
            run_len   = 1;
        end
    endfunction

    task automatic send_pixel(input logic signed [hrs_pkg::HEIGHT_W-1:0] h, input logic rs);
        shade_write_t w;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.height    <= h;
        in_ch.row_start <= rs;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        predict_shades(h, rs);
        for (int i = 0; i < pixel_cols.size(); i++)
        begin
            w.column = hrs_pkg::COL_W'(pixel_cols[i]);
            w.shade  = hrs_pkg::SHADE_W'(pixel_shades[i]);
            w.last   = (i == pixel_cols.size() - 1);
            pending_shades.push_back(w);
        end
    endtask

    task automatic send_level(input int lvl, input logic rs);
        send_pixel(hrs_pkg::HEIGHT_W'(lvl * 8 + int'($urandom_range(7))), rs);
    endtask

    task automatic pause_sender();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_shades.size() != 0);
    endtask

    task automatic note_mismatch(input string what, input shade_write_t want,
                                 input shade_write_t got);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s: expected col %0d shade %0d last %0b, got col %0d shade %0d last %0b",
                     $realtime, what, want.column, want.shade, want.last,
                     got.column, got.shade, got.last);
    endtask

    always @(posedge clk)
    begin : check_writes
        shade_write_t want;
        shade_write_t got;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got.column = out_ch.column;
            got.shade  = out_ch.shade;
            got.last   = out_ch.last;
            if (pending_shades.size() == 0)
            begin
                note_mismatch("write with none expected", '0, got);
            end
            else
            begin
                want = pending_shades.pop_front();
                if (got.column !== want.column || got.shade !== want.shade
                    || got.last !== want.last)
                    note_mismatch("shade write mismatch", want, got);
            end
        end
    end

    task automatic test_first_pixel_without_row_start();
        send_pixel(16'sh1234, 1'b0);
        send_level(583, 1'b0);
        pause_sender();
    endtask

    task automatic test_height_extremes();
        send_pixel(16'sh8000, 1'b1);
        send_pixel(16'sh7FFF, 1'b0);
        send_pixel(16'sh8000, 1'b0);
        send_pixel(16'sh5555, 1'b0);
        send_pixel(16'shAAAA, 1'b0);
        send_pixel(16'sh7FFF, 1'b0);
        pause_sender();
    endtask

    task automatic test_descent_darkening();
        send_level(20, 1'b1);
        send_level(19, 1'b0);
        send_level(19, 1'b0);
        send_level(19, 1'b0);
        send_level(18, 1'b0);
        send_level(18, 1'b0);
        send_level(21, 1'b0);
        send_level(22, 1'b0);
        pause_sender();
    endtask

    task automatic test_shadow_cast();
        send_level(30, 1'b1);
        send_level(25, 1'b0);
        send_level(24, 1'b0);
        send_level(28, 1'b0);
        send_level(27, 1'b0);
        send_level(18, 1'b0);
        send_level(18, 1'b0);
        pause_sender();
    endtask

    // highlight and darken runs longer than the table, then pixels past the row end
    task automatic test_row_overflow();
        int lvl;
        for (int c = 0; c < ROW_MAX + 6; c++)
        begin
            if (c >= ROW_MAX)
            begin
                send_pixel(hrs_pkg::HEIGHT_W'($urandom), 1'b0);
            end
            else
            begin
                if (c < 80)
                    lvl = 5;
                else if (c < 200)
                    lvl = 6;
                else if (c < 300)
                    lvl = 5;
                else if (c < 400)
                    lvl = 4;
                else if (c < 420)
                    lvl = 9;
                else if (c < ROW_MAX - 1)
                    lvl = 1;
                else
                    lvl = 2;
                send_level(lvl, c == 0);
            end
        end
        pause_sender();
        send_level(7, 1'b1);
        send_level(8, 1'b0);
        pause_sender();
    endtask

    task automatic test_full_queue_stall();
        int lvl;
        lvl = 100;
        hold_len = 300;
        for (int c = 0; c < 40; c++)
        begin
            if (c % 3 == 2)
                lvl++;
            send_level(lvl, c == 0);
        end
        pause_sender();
    endtask

    task automatic test_random_rows(input int src_idle, input int snk_stall, input int n_items);
        int sent;
        int len;
        int lvl;
        int r;
        bit noisy;
        bit with_rs;
        src_idle_pct  = src_idle;
        snk_stall_pct = snk_stall;
        sent = 0;
        while (sent < n_items)
        begin
            len     = ($urandom_range(9) == 0) ? $urandom_range(150, 60) : $urandom_range(30, 2);
            noisy   = ($urandom_range(9) == 0);
            with_rs = ($urandom_range(11) != 0);
            if ($urandom_range(4) == 0)
                lvl = $urandom_range(1) ? LEVEL_HI - int'($urandom_range(20))
                                        : LEVEL_LO + int'($urandom_range(20));
            else
                lvl = int'($urandom_range(400)) - 200;
            for (int c = 0; c < len; c++)
            begin
                if (noisy)
                begin
                    send_pixel(hrs_pkg::HEIGHT_W'($urandom),
                               (c == 0) ? with_rs : ($urandom_range(15) == 0));
                end
                else
                begin
                    r = $urandom_range(99);
                    if (r < 40)
                        lvl = lvl;
                    else if (r < 55)
                        lvl = lvl + 1;
                    else if (r < 70)
                        lvl = lvl - 1;
                    else if (r < 82)
                        lvl = lvl + int'($urandom_range(40, 2));
                    else if (r < 94)
                        lvl = lvl - int'($urandom_range(60, 2));
                    else
                        lvl = int'($urandom_range(8191)) + LEVEL_LO;
                    if (lvl > LEVEL_HI)
                        lvl = LEVEL_HI;
                    if (lvl < LEVEL_LO)
                        lvl = LEVEL_LO;
                    send_level(lvl, (c == 0) && with_rs);
                end
                sent++;
            end
        end
        pause_sender();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
    endtask

    initial
    begin
        in_ch.valid     = 1'b0;
        in_ch.height    = '0;
        in_ch.row_start = 1'b0;
        rst_n           = 1'b0;
        clear_row_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_pixel_without_row_start();
        test_height_extremes();
        test_descent_darkening();
        test_shadow_cast();
        test_row_overflow();
        test_full_queue_stall();
        test_random_rows(0, 0, 105);
        test_random_rows(51, 0, 105);
        test_random_rows(0, 51, 105);
        test_random_rows(20, 20, 105);

        repeat (60) @(posedge clk);
        if (error_count == 0 && pending_shades.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
